// ===== hdl/rfd_pkg.sv =====
// rfd_pkg: shared types and codes for the rpc frame deframer
// parse phase codes, result kinds, status codes and register indexes
// no dependencies
package rfd_pkg;

   typedef logic [3:0] phase_type;
   typedef logic [2:0] kind_type;
   typedef logic [1:0] status_type;
   typedef logic [1:0] csr_index_type;

   localparam phase_type PH_HUNT    = 4'd0;
   localparam phase_type PH_TOTAL   = 4'd1;
   localparam phase_type PH_IDLEN   = 4'd2;
   localparam phase_type PH_ID      = 4'd3;
   localparam phase_type PH_MLEN    = 4'd4;
   localparam phase_type PH_METHOD  = 4'd5;
   localparam phase_type PH_ERRCODE = 4'd6;
   localparam phase_type PH_ELEN    = 4'd7;
   localparam phase_type PH_ETEXT   = 4'd8;
   localparam phase_type PH_PAYLOAD = 4'd9;
   localparam phase_type PH_CKSUM   = 4'd10;
   localparam phase_type PH_END     = 4'd11;
   localparam phase_type PH_SKIP    = 4'd12;

   localparam kind_type KIND_ID      = 3'd0;
   localparam kind_type KIND_METHOD  = 3'd1;
   localparam kind_type KIND_ETEXT   = 3'd2;
   localparam kind_type KIND_PAYLOAD = 3'd3;
   localparam kind_type KIND_STATUS  = 3'd4;

   localparam status_type ST_GOOD      = 2'd0;
   localparam status_type ST_BAD_END   = 2'd1;
   localparam status_type ST_OVERRUN   = 2'd2;
   localparam status_type ST_BAD_TOTAL = 2'd3;

   localparam csr_index_type CSR_START_BYTE    = 2'd0;
   localparam csr_index_type CSR_END_BYTE      = 2'd1;
   localparam csr_index_type CSR_MAX_FRAME_LEN = 2'd2;

   localparam logic [31:0] FIXED_BYTES   = 32'd26;
   localparam logic [16:0] ID_TAIL       = 17'd17;
   localparam logic [16:0] METHOD_TAIL   = 17'd13;
   localparam logic [15:0] TRAILER_BYTES = 16'd5;

endpackage

// ===== hdl/rpc_frame_deframer.sv =====
// rpc_frame_deframer: splits a length-prefixed rpc byte stream into tagged field beats
// and one status beat per frame; depends on rfd_pkg
// path: input byte register, then the phase update, then the result register
// throughput: one byte per cycle unless rsp_stall holds a valid result, which
//   also holds the input byte register and raises req_stall
// reset: synchronous, clears phase, counters, held error code and both valid flags,
//   and loads the register defaults (start 2, end 3, max length 65535)
module rpc_frame_deframer #(
   parameter int LEN_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [7:0]                req_in_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rfd_pkg::kind_type         rsp_field_kind,
   output logic [7:0]                rsp_field_byte,
   output logic signed [31:0]        rsp_error_code_value,
   output rfd_pkg::status_type       rsp_frame_status,
   output logic                      rsp_frame_last,
   input  logic                      csr_write,
   input  rfd_pkg::csr_index_type    csr_index,
   input  logic [15:0]               csr_data
);
   import rfd_pkg::*;

   logic [7:0]  start_ff, end_ff;
   logic [15:0] maxlen_ff;

   logic        byte_valid_ff;
   logic [7:0]  byte_ff;

   phase_type   phase_ff, phase_in;
   logic [23:0] word_ff, word_in;
   logic [1:0]  count_ff, count_in;
   logic [15:0] part_ff, part_in;
   logic [15:0] left_ff, left_in;
   logic [31:0] held_ff, held_in;

   logic        rsp_valid_ff;
   kind_type    kind_ff;
   logic [7:0]  fbyte_ff;
   logic [31:0] code_ff;
   status_type  status_ff;
   logic        last_ff;

   logic        advance, fire;
   logic [31:0] word_full;
   logic [15:0] left_dec, part_dec, pay_len;
   logic        word_done, too_wide, total_bad, id_fits, method_fits, etext_fits;
   logic        res_valid;
   kind_type    res_kind;
   logic [7:0]  res_byte;
   status_type  res_status;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign fire      = byte_valid_ff && advance;
   assign req_stall = byte_valid_ff && !advance;

   assign word_full = {word_ff, byte_ff};
   assign word_done = (count_ff == 2'd3);
   assign left_dec  = (left_ff != 16'd0) ? left_ff - 16'd1 : 16'd0;
   assign part_dec  = part_ff - 16'd1;
   assign pay_len   = (left_dec >= TRAILER_BYTES) ? left_dec - TRAILER_BYTES : 16'd0;
   assign too_wide  = (word_full >> LEN_BITS) != 32'd0;
   assign total_bad = (word_full < FIXED_BYTES) || (word_full > {16'd0, maxlen_ff}) ||
                      too_wide;
   assign id_fits     = !too_wide && (word_full[31:16] == 16'd0) &&
                        ({1'b0, word_full[15:0]} + ID_TAIL <= {1'b0, left_dec});
   assign method_fits = !too_wide && (word_full[31:16] == 16'd0) &&
                        ({1'b0, word_full[15:0]} + METHOD_TAIL <= {1'b0, left_dec});
   assign etext_fits  = !too_wide && (word_full[31:16] == 16'd0) &&
                        ({1'b0, word_full[15:0]} + {1'b0, TRAILER_BYTES} <= {1'b0, left_dec});

   always_comb begin
      phase_in   = phase_ff;
      word_in    = word_ff;
      count_in   = count_ff;
      part_in    = part_ff;
      left_in    = (phase_ff == PH_HUNT || phase_ff == PH_TOTAL) ? left_ff : left_dec;
      held_in    = held_ff;
      res_valid  = 1'b0;
      res_kind   = KIND_STATUS;
      res_byte   = byte_ff;
      res_status = ST_GOOD;
      case (phase_ff)
         PH_HUNT: begin
            if (byte_ff == start_ff) begin
               held_in  = 32'd0;
               left_in  = 16'd0;
               part_in  = 16'd0;
               count_in = 2'd0;
               phase_in = PH_TOTAL;
            end
         end
         PH_ID, PH_METHOD, PH_ETEXT, PH_PAYLOAD: begin
            part_in   = part_dec;
            res_valid = 1'b1;
            case (phase_ff)
               PH_ID:     res_kind = KIND_ID;
               PH_METHOD: res_kind = KIND_METHOD;
               PH_ETEXT:  res_kind = KIND_ETEXT;
               default:   res_kind = KIND_PAYLOAD;
            endcase
            if (part_dec == 16'd0) begin
               case (phase_ff)
                  PH_ID:     phase_in = PH_MLEN;
                  PH_METHOD: phase_in = PH_ERRCODE;
                  PH_ETEXT: begin
                     part_in  = pay_len;
                     phase_in = (pay_len == 16'd0) ? PH_CKSUM : PH_PAYLOAD;
                  end
                  default:   phase_in = PH_CKSUM;
               endcase
            end
         end
         PH_END: begin
            phase_in   = PH_HUNT;
            res_valid  = 1'b1;
            res_status = (byte_ff == end_ff) ? ST_GOOD : ST_BAD_END;
         end
         PH_SKIP: begin
            if (left_dec == 16'd0) begin
               phase_in = PH_HUNT;
            end
         end
         PH_TOTAL, PH_IDLEN, PH_MLEN, PH_ERRCODE, PH_ELEN, PH_CKSUM: begin
            word_in  = word_full[23:0];
            count_in = count_ff + 2'd1;
            if (word_done) begin
               case (phase_ff)
                  PH_TOTAL: begin
                     if (total_bad) begin
                        phase_in   = PH_HUNT;
                        res_valid  = 1'b1;
                        res_status = ST_BAD_TOTAL;
                     end else begin
                        left_in  = word_full[15:0] - TRAILER_BYTES;
                        phase_in = PH_IDLEN;
                     end
                  end
                  PH_IDLEN: begin
                     if (!id_fits) begin
                        phase_in   = (left_dec == 16'd0) ? PH_HUNT : PH_SKIP;
                        res_valid  = 1'b1;
                        res_status = ST_OVERRUN;
                     end else begin
                        part_in  = word_full[15:0];
                        phase_in = (word_full[15:0] == 16'd0) ? PH_MLEN : PH_ID;
                     end
                  end
                  PH_MLEN: begin
                     if (!method_fits) begin
                        phase_in   = (left_dec == 16'd0) ? PH_HUNT : PH_SKIP;
                        res_valid  = 1'b1;
                        res_status = ST_OVERRUN;
                     end else begin
                        part_in  = word_full[15:0];
                        phase_in = (word_full[15:0] == 16'd0) ? PH_ERRCODE : PH_METHOD;
                     end
                  end
                  PH_ERRCODE: begin
                     held_in  = word_full;
                     phase_in = PH_ELEN;
                  end
                  PH_ELEN: begin
                     if (!etext_fits) begin
                        phase_in   = (left_dec == 16'd0) ? PH_HUNT : PH_SKIP;
                        res_valid  = 1'b1;
                        res_status = ST_OVERRUN;
                     end else if (word_full[15:0] != 16'd0) begin
                        part_in  = word_full[15:0];
                        phase_in = PH_ETEXT;
                     end else begin
                        part_in  = pay_len;
                        phase_in = (pay_len == 16'd0) ? PH_CKSUM : PH_PAYLOAD;
                     end
                  end
                  default: phase_in = PH_END;
               endcase
            end
         end
         default: phase_in = PH_HUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= 8'd2;
         end_ff    <= 8'd3;
         maxlen_ff <= 16'hFFFF;
      end else if (csr_write) begin
         case (csr_index)
            CSR_START_BYTE:    start_ff  <= csr_data[7:0];
            CSR_END_BYTE:      end_ff    <= csr_data[7:0];
            CSR_MAX_FRAME_LEN: maxlen_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input byte stage
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         byte_valid_ff <= req_valid;
      end
      if (req_valid && !req_stall) begin
         byte_ff <= req_in_byte;
      end
   end

   // parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= 2'd0;
         part_ff  <= 16'd0;
         left_ff  <= 16'd0;
         held_ff  <= 32'd0;
      end else if (fire) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         part_ff  <= part_in;
         left_ff  <= left_in;
         held_ff  <= held_in;
      end
      if (fire) begin
         word_ff <= word_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fire && res_valid;
      end
      if (fire && res_valid) begin
         kind_ff   <= res_kind;
         fbyte_ff  <= (res_kind == KIND_STATUS) ? 8'd0 : res_byte;
         code_ff   <= (res_kind == KIND_STATUS) ? held_ff : 32'd0;
         status_ff <= (res_kind == KIND_STATUS) ? res_status : ST_GOOD;
         last_ff   <= (res_kind == KIND_STATUS);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_field_kind       = kind_ff;
   assign rsp_field_byte       = fbyte_ff;
   assign rsp_error_code_value = signed'(code_ff);
   assign rsp_frame_status     = status_ff;
   assign rsp_frame_last       = last_ff;

   // a bad total length is caught before any error code is read
   a_bad_total_code_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_kind == KIND_STATUS && rsp_frame_status == ST_BAD_TOTAL
      |-> rsp_error_code_value == 32'sd0)
      else $error("bad total length status with nonzero error code");

   // data beats never close a frame
   a_data_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_field_kind != KIND_STATUS
      |-> !rsp_frame_last && rsp_frame_status == ST_GOOD)
      else $error("data beat flagged as frame end");

   // word byte count is aligned outside the four-byte word phases
   a_count_aligned: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HUNT || phase_ff == PH_ID || phase_ff == PH_METHOD ||
      phase_ff == PH_ETEXT || phase_ff == PH_PAYLOAD || phase_ff == PH_SKIP
      |-> count_ff == 2'd0)
      else $error("word byte count misaligned");

   // skipping only while frame bytes remain
   a_skip_has_bytes: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> left_ff != 16'd0)
      else $error("skip phase with no frame bytes left");

endmodule

// ===== test/testbench.sv =====
// testbench for rpc_frame_deframer: byte stream of well-formed, damaged and noisy frames
// checked beat by beat against a behavioral deframer kept in this file
// depends on rfd_pkg and the rpc_frame_deframer rtl
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rfd_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int BYTES_PER_SET  = 95;
   localparam int SETTING_COUNT  = 5;
   localparam int DIRECTED_COUNT = 21;
   localparam logic FROM_MODEL   = 1'b0;
   localparam logic FIXED_RESULT = 1'b1;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [31:0] code;
      status_type  status;
      logic        last;
   } field_beat_type;

   typedef struct packed {
      logic       typed;
      status_type status;
      logic [7:0] data;
   } script_row_type;

   logic                clock;
   logic                reset       = 1'b1;
   logic                req_valid   = 1'b0;
   logic                req_stall;
   logic [7:0]          req_in_byte = 8'h00;
   logic                rsp_valid;
   logic                rsp_stall   = 1'b0;
   kind_type            rsp_field_kind;
   logic [7:0]          rsp_field_byte;
   logic signed [31:0]  rsp_error_code_value;
   status_type          rsp_frame_status;
   logic                rsp_frame_last;
   logic                csr_write   = 1'b0;
   csr_index_type       csr_index   = CSR_START_BYTE;
   logic [15:0]         csr_data    = 16'h0000;

   logic                steady      = 1'b0;
   int                  cycle_count = 0;
   int                  mismatches  = 0;
   int                  beats_checked = 0;
   int                  status_beats  = 0;
   int                  frames_sent   = 0;
   int                  bytes_fed     = 0;
   int                  settings_used = 0;

   field_beat_type      pending_beats[$];
   field_beat_type      seen_beat;
   field_beat_type      want_beat;
   logic [7:0]          frame_bytes[$];
   script_row_type      directed_rows [DIRECTED_COUNT];

   // deframer state and register copies
   phase_type           phase_now;
   logic [31:0]         acc_word;
   logic [1:0]          acc_count;
   logic [15:0]         part_left;
   logic [15:0]         frame_left;
   logic [31:0]         code_held;
   logic [7:0]          cfg_start;
   logic [7:0]          cfg_end;
   logic [15:0]         cfg_max;

   rpc_frame_deframer DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_in_byte          (req_in_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_field_kind       (rsp_field_kind),
      .rsp_field_byte       (rsp_field_byte),
      .rsp_error_code_value (rsp_error_code_value),
      .rsp_frame_status     (rsp_frame_status),
      .rsp_frame_last       (rsp_frame_last),
      .csr_write            (csr_write),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic phase_type following_part(input phase_type ph);
      case (ph)
         PH_ID:     return PH_MLEN;
         PH_METHOD: return PH_ERRCODE;
         PH_ETEXT:  return PH_PAYLOAD;
         default:   return PH_CKSUM;
      endcase
   endfunction

   // zero-length parts fall straight through to the next one
   function automatic void advance_to(input phase_type ph);
      phase_type p;
      logic      settled;
      p = ph;
      settled = 1'b0;
      acc_word = 32'h0;
      acc_count = 2'd0;
      while (!settled) begin
         case (p)
            PH_ID, PH_METHOD, PH_ETEXT: begin
               if (part_left == 16'd0) p = following_part(p);
               else settled = 1'b1;
            end
            PH_PAYLOAD: begin
               part_left = (frame_left >= TRAILER_BYTES) ? frame_left - TRAILER_BYTES : 16'd0;
               if (part_left == 16'd0) p = PH_CKSUM;
               else settled = 1'b1;
            end
            default: settled = 1'b1;
         endcase
      end
      phase_now = p;
   endfunction

   function automatic field_beat_type close_beat(input status_type st);
      field_beat_type r;
      r.kind = KIND_STATUS;
      r.data = 8'h00;
      r.code = code_held;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic logic predict_deframe(input logic [7:0] b, output field_beat_type beat);
      phase_type   ph;
      logic [31:0] w;
      logic [16:0] tail;
      logic        word_done;
      ph = phase_now;
      beat = '0;
      if (ph == PH_HUNT) begin
         if (b == cfg_start) begin
            code_held = 32'h0;
            frame_left = 16'd0;
            part_left = 16'd0;
            advance_to(PH_TOTAL);
         end
         return 1'b0;
      end
      if (ph != PH_TOTAL && frame_left != 16'd0) frame_left = frame_left - 16'd1;
      case (ph)
         PH_ID, PH_METHOD, PH_ETEXT, PH_PAYLOAD: begin
            part_left = part_left - 16'd1;
            beat.kind = (ph == PH_ID) ? KIND_ID : (ph == PH_METHOD) ? KIND_METHOD :
                        (ph == PH_ETEXT) ? KIND_ETEXT : KIND_PAYLOAD;
            beat.data = b;
            if (part_left == 16'd0) advance_to(following_part(ph));
            return 1'b1;
         end
         PH_END: begin
            phase_now = PH_HUNT;
            beat = close_beat((b == cfg_end) ? ST_GOOD : ST_BAD_END);
            return 1'b1;
         end
         PH_SKIP: begin
            if (frame_left == 16'd0) phase_now = PH_HUNT;
            return 1'b0;
         end
         PH_TOTAL, PH_IDLEN, PH_MLEN, PH_ERRCODE, PH_ELEN, PH_CKSUM: ;
         default: begin
            phase_now = PH_HUNT;
            return 1'b0;
         end
      endcase
      acc_word = {acc_word[23:0], b};
      word_done = (acc_count == 2'd3);
      acc_count = acc_count + 2'd1;
      if (!word_done) return 1'b0;
      w = acc_word;
      case (ph)
         PH_TOTAL: begin
            if (w < FIXED_BYTES || w > {16'h0, cfg_max} || w[31:16] != 16'h0) begin
               phase_now = PH_HUNT;
               beat = close_beat(ST_BAD_TOTAL);
               return 1'b1;
            end
            frame_left = w[15:0] - TRAILER_BYTES;
            advance_to(PH_IDLEN);
         end
         PH_IDLEN, PH_MLEN, PH_ELEN: begin
            tail = (ph == PH_IDLEN) ? ID_TAIL : (ph == PH_MLEN) ? METHOD_TAIL
                                                                : {1'b0, TRAILER_BYTES};
            if (w[31:16] != 16'h0 || {1'b0, w[15:0]} + tail > {1'b0, frame_left}) begin
               phase_now = (frame_left == 16'd0) ? PH_HUNT : PH_SKIP;
               beat = close_beat(ST_OVERRUN);
               return 1'b1;
            end
            part_left = w[15:0];
            advance_to((ph == PH_IDLEN) ? PH_ID : (ph == PH_MLEN) ? PH_METHOD : PH_ETEXT);
         end
         PH_ERRCODE: begin
            code_held = w;
            advance_to(PH_ELEN);
         end
         default: advance_to(PH_END);
      endcase
      return 1'b0;
   endfunction

   task automatic feed_byte(input logic [7:0] b, output logic got, output field_beat_type beat);
      while (!steady && $urandom_range(99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = predict_deframe(b, beat);
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (pending_beats.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (pending_beats.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, pending_beats.size());
         mismatches += pending_beats.size();
         pending_beats.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] s, input logic [7:0] e,
                                 input logic [15:0] m);
      csr_write <= 1'b1;
      csr_index <= CSR_START_BYTE;
      csr_data <= {8'h00, s};
      @(posedge clock);
      csr_index <= CSR_END_BYTE;
      csr_data <= {8'h00, e};
      @(posedge clock);
      csr_index <= CSR_MAX_FRAME_LEN;
      csr_data <= m;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_start = s;
      cfg_end = e;
      cfg_max = m;
      settings_used++;
   endtask

   function automatic void add_word(input logic [31:0] w);
      frame_bytes.push_back(w[31:24]);
      frame_bytes.push_back(w[23:16]);
      frame_bytes.push_back(w[15:8]);
      frame_bytes.push_back(w[7:0]);
   endfunction

   function automatic void add_text(input int n);
      repeat (n) frame_bytes.push_back(8'($urandom));
   endfunction

   function automatic int part_size();
      return ($urandom_range(9) < 7) ? int'($urandom_range(0, 4)) : int'($urandom_range(5, 40));
   endfunction

   // mostly good frames; the rest have a bad end, total or text length, or are cut short
   task automatic send_random_frame();
      int             id_n, m_n, e_n, p_n, mode, k, delta, cut;
      logic [31:0]    tw, idw, mw, ew, code;
      logic [7:0]     endb, flip, b;
      logic           got;
      field_beat_type beat;
      id_n = part_size();
      m_n = part_size();
      e_n = part_size();
      p_n = part_size();
      tw = FIXED_BYTES + 32'(id_n + m_n + e_n + p_n);
      if (tw > {16'h0, cfg_max}) begin
         id_n = 0;
         m_n = 0;
         e_n = 0;
         p_n = 0;
         tw = FIXED_BYTES;
      end
      idw = 32'(id_n);
      mw = 32'(m_n);
      ew = 32'(e_n);
      endb = cfg_end;
      case ($urandom_range(5))
         0: code = 32'h8000_0000;
         1: code = 32'h7FFF_FFFF;
         2: code = 32'h0000_0000;
         3: code = 32'hFFFF_FFFF;
         default: code = $urandom;
      endcase
      mode = $urandom_range(99);
      if (mode >= 70 && mode < 78) begin
         flip = 8'($urandom_range(1, 255));
         endb = cfg_end ^ flip;
      end else if (mode >= 78 && mode < 86) begin
         case ($urandom_range(2))
            0: tw = $urandom_range(0, 25);
            1: tw = (cfg_max == 16'hFFFF) ? 32'h1_0000 + $urandom_range(0, 255)
                                          : $urandom_range(cfg_max + 1, 65535);
            default: tw = $urandom;
         endcase
      end else if (mode >= 86 && mode < 94) begin
         // delta of zero lands exactly on the room left
         k = $urandom_range(2);
         delta = $urandom_range(0, 3);
         if ($urandom_range(3) == 0) begin
            if (k == 0) idw = $urandom | 32'h1_0000;
            else if (k == 1) mw = $urandom | 32'h1_0000;
            else ew = $urandom | 32'h1_0000;
         end else begin
            if (k == 0) idw = 32'(id_n + m_n + e_n + p_n + delta);
            else if (k == 1) mw = 32'(m_n + e_n + p_n + delta);
            else ew = 32'(e_n + p_n + delta);
         end
      end
      frame_bytes.delete();
      frame_bytes.push_back(cfg_start);
      add_word(tw);
      add_word(idw);
      add_text(id_n);
      add_word(mw);
      add_text(m_n);
      add_word(code);
      add_word(ew);
      add_text(e_n);
      add_text(p_n);
      add_word($urandom);
      frame_bytes.push_back(endb);
      if (mode >= 94) begin
         cut = $urandom_range(1, frame_bytes.size() - 1);
         while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      end
      bytes_fed += frame_bytes.size();
      repeat ($urandom_range(0, 3)) begin
         b = 8'($urandom);
         if (b == cfg_start && $urandom_range(19) != 0) b = ~b;
         frame_bytes.push_back(b);
      end
      foreach (frame_bytes[i]) begin
         feed_byte(frame_bytes[i], got, beat);
         if (got) pending_beats.push_back(beat);
      end
      frames_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_beat = {rsp_field_kind, rsp_field_byte, rsp_error_code_value,
                      rsp_frame_status, rsp_frame_last};
         beats_checked++;
         if (seen_beat.kind == KIND_STATUS) status_beats++;
         if (pending_beats.size() == 0) begin
            $display("%0t: beat with none expected: kind %0d byte %h code %h status %0d last %0b",
                     $time, seen_beat.kind, seen_beat.data, seen_beat.code, seen_beat.status,
                     seen_beat.last);
            mismatches++;
         end else begin
            want_beat = pending_beats.pop_front();
            if (seen_beat !== want_beat) begin
               $display({"%0t: expected kind %0d byte %h code %h status %0d last %0b,",
                         " actual kind %0d byte %h code %h status %0d last %0b"},
                        $time, want_beat.kind, want_beat.data, want_beat.code,
                        want_beat.status, want_beat.last, seen_beat.kind, seen_beat.data,
                        seen_beat.code, seen_beat.status, seen_beat.last);
               mismatches++;
            end
         end
      end
      rsp_stall <= !reset && !steady && ($urandom_range(99) < 26);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      logic           got;
      field_beat_type beat;
      logic [7:0]     s, e;
      logic [15:0]    m;
      int             placed;
      directed_rows = '{
         {FROM_MODEL, ST_GOOD, 8'h00}, {FROM_MODEL, ST_GOOD, 8'hFF},
         // total below the fixed part
         {FROM_MODEL, ST_GOOD, 8'h02}, {FROM_MODEL, ST_GOOD, 8'h00},
         {FROM_MODEL, ST_GOOD, 8'h00}, {FROM_MODEL, ST_GOOD, 8'h00},
         {FIXED_RESULT, ST_BAD_TOTAL, 8'h19},
         // total wider than the length field
         {FROM_MODEL, ST_GOOD, 8'h02}, {FROM_MODEL, ST_GOOD, 8'h00},
         {FROM_MODEL, ST_GOOD, 8'h01}, {FROM_MODEL, ST_GOOD, 8'h00},
         {FIXED_RESULT, ST_BAD_TOTAL, 8'h00},
         // minimal total, then an id length of all ones
         {FROM_MODEL, ST_GOOD, 8'h02}, {FROM_MODEL, ST_GOOD, 8'h00},
         {FROM_MODEL, ST_GOOD, 8'h00}, {FROM_MODEL, ST_GOOD, 8'h00},
         {FROM_MODEL, ST_GOOD, 8'h1A}, {FROM_MODEL, ST_GOOD, 8'hFF},
         {FROM_MODEL, ST_GOOD, 8'hFF}, {FROM_MODEL, ST_GOOD, 8'hFF},
         {FIXED_RESULT, ST_OVERRUN, 8'hFF}
      };
      phase_now = PH_HUNT;
      acc_word = 32'h0;
      acc_count = 2'd0;
      part_left = 16'd0;
      frame_left = 16'd0;
      code_held = 32'h0;
      cfg_start = 8'd2;
      cfg_end = 8'd3;
      cfg_max = 16'hFFFF;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         feed_byte(directed_rows[i].data, got, beat);
         if (directed_rows[i].typed)
            pending_beats.push_back({KIND_STATUS, 8'h00, 32'h0, directed_rows[i].status, 1'b1});
         else if (got)
            pending_beats.push_back(beat);
      end
      drain();
      for (int set_no = 0; set_no < SETTING_COUNT; set_no++) begin
         case (set_no)
            0: begin s = 8'h02; e = 8'h03; m = 16'hFFFF; end
            1: begin s = 8'h00; e = 8'hFF; m = 16'd26; end
            2: begin s = 8'hFF; e = 8'h00; m = 16'hFFFF; end
            3: begin
               s = 8'($urandom);
               e = 8'($urandom);
               m = 16'($urandom_range(26, 400));
            end
            default: begin s = 8'h7E; e = 8'h7E; m = 16'd60; end
         endcase
         apply_settings(s, e, m);
         steady <= (set_no == 1);
         placed = bytes_fed;
         while (bytes_fed - placed < BYTES_PER_SET) send_random_frame();
         drain();
      end
      $display("fed %0d frames (%0d frame bytes) under %0d register settings",
               frames_sent, bytes_fed, settings_used);
      $display("checked %0d result beats, %0d of them frame status", beats_checked,
               status_beats);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/rfd_pkg.sv
hdl/rpc_frame_deframer.sv
test/testbench.sv
